### rtl/euler_zyx_to_rotation_matrix_assert.svh
// Assertion macros for the ZYX Euler to rotation matrix block
`ifndef EULER_ZYX_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ZYX_TO_ROTATION_MATRIX_ASSERT_SVH

// same-cycle implication, checked on every rising clk outside reset
`define EZR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ezr assertion failed");

// next-cycle implication
`define EZR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ezr assertion failed");

`endif

### rtl/ezr_pkg.sv
// Shared types, constants and fixed-point helpers for the rotation matrix block
package ezr_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int FRAC_BITS     = 14;
	localparam int ELEM_BITS     = FRAC_BITS + 2;
	localparam int CORDIC_STAGES = 20;
	localparam int CW            = 34;
	localparam int PIPE_LAT      = CORDIC_STAGES + 5;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic signed [CW-1:0] CORDIC_ONE  = 34'sd1073741824;

	localparam logic [31:0] ATAN_TAB [CORDIC_STAGES] = '{
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335086,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
		32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303
	};

	localparam logic signed [CW-1:0] ELEM_ROUND = 34'sd1 <<< (29 - FRAC_BITS);
	localparam logic signed [CW-1:0] ELEM_LIM   = 34'sd1 <<< FRAC_BITS;

	typedef logic signed [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [ELEM_BITS-1:0]  elem_t;
	typedef logic signed [31:0]           q30_t;

	typedef struct packed {
		angle_t roll_angle;
		angle_t pitch_angle;
		angle_t yaw_angle;
	} angles_t;

	typedef struct packed {
		elem_t m00;
		elem_t m01;
		elem_t m02;
		elem_t m10;
		elem_t m11;
		elem_t m12;
		elem_t m20;
		elem_t m21;
		elem_t m22;
	} matrix_t;

	// Q30 times Q30, rounded back to Q30
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		p = a * b;
		p = p + (64'sd1 <<< 29);
		return p[61:30];
	endfunction

	// Q30 to Q1.FRAC_BITS with rounding and saturation
	function automatic elem_t to_elem(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + ELEM_ROUND) >>> (30 - FRAC_BITS);
		if (r > ELEM_LIM) begin
			r = ELEM_LIM;
		end else if (r < -ELEM_LIM) begin
			r = -ELEM_LIM;
		end
		return r[ELEM_BITS-1:0];
	endfunction

endpackage

### rtl/ezr_sincos.sv
// Pipelined rotation-mode CORDIC giving Q30 sine and cosine of a binary angle
module ezr_sincos import ezr_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  angle_t angle,
	output q30_t   sin_q,
	output q30_t   cos_q
);

	logic [31:0]          phase;
	logic [31:0]          phase_t;
	logic                 flip;
	logic signed [CW-1:0] x_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] z_s [CORDIC_STAGES+1];
	logic                 flip_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] xc;
	logic signed [CW-1:0] yc;

	always_comb begin
		phase = {angle, {(32-ANGLE_BITS){1'b0}}};
		flip  = (phase > 32'h4000_0000) && (phase < 32'hC000_0000);
		// turn the back half-plane by pi, negate at the end
		phase_t = flip ? phase + 32'h8000_0000 : phase;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= {{(CW-32){phase_t[31]}}, phase_t};
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		logic signed [CW-1:0] atan_v;
		assign atan_v = {{(CW-32){1'b0}}, ATAN_TAB[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_v;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_v;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	always_comb begin
		xc = x_s[CORDIC_STAGES];
		yc = y_s[CORDIC_STAGES];
		if (xc > CORDIC_ONE) xc = CORDIC_ONE;
		else if (xc < -CORDIC_ONE) xc = -CORDIC_ONE;
		if (yc > CORDIC_ONE) yc = CORDIC_ONE;
		else if (yc < -CORDIC_ONE) yc = -CORDIC_ONE;
		if (flip_s[CORDIC_STAGES]) begin
			xc = -xc;
			yc = -yc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= yc[31:0];
			cos_q <= xc[31:0];
		end
	end

endmodule

### rtl/euler_zyx_to_rotation_matrix.sv
// Top level: ZYX Euler angles to Q1.14 rotation matrix, fully pipelined
//
//  channel  | valid        | stall        | payload
//  angles   | angle_valid  | angle_stall  | angles (roll, pitch, yaw)
//  matrix   | mat_valid    | mat_stall    | matrix (m00 .. m22)
//
// One request enters per cycle while angle_stall is low. A request passes through the CORDIC
// (entry, 20 micro-rotations, clamp) and then through the product stages.
// Reset clears only the valid bits; the data registers are not reset.
// The whole pipeline holds while a result waits under mat_stall, else it advances.
module euler_zyx_to_rotation_matrix import ezr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    angle_valid,
	output logic    angle_stall,
	input  angles_t angles,
	output logic    mat_valid,
	input  logic    mat_stall,
	output matrix_t matrix
);

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;
	q30_t sr, cr, sp, cp, sy, cy;

	// stage 1 of the products
	q30_t cysp_s1, sysp_s1, cycp_s1, sycp_s1, sycr_s1, sysr_s1;
	q30_t cycr_s1, cysr_s1, cpsr_s1, cpcr_s1, sr_s1, cr_s1, sp_s1;
	// stage 2
	q30_t t01_s2, t02_s2, t11_s2, t12_s2;
	q30_t cycp_s2, sycp_s2, sycr_s2, sysr_s2, cycr_s2, cysr_s2, cpsr_s2, cpcr_s2, sp_s2;
	matrix_t mat_s3;

	assign en          = !vld_q[PIPE_LAT-1] || !mat_stall;
	assign angle_stall = !en;
	assign mat_valid   = vld_q[PIPE_LAT-1];
	assign matrix      = mat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], angle_valid};
		end
	end

	ezr_sincos u_roll  (.clk, .en, .angle(angles.roll_angle),  .sin_q(sr), .cos_q(cr));
	ezr_sincos u_pitch (.clk, .en, .angle(angles.pitch_angle), .sin_q(sp), .cos_q(cp));
	ezr_sincos u_yaw   (.clk, .en, .angle(angles.yaw_angle),   .sin_q(sy), .cos_q(cy));

	always_ff @(posedge clk) begin
		if (en) begin
			cysp_s1 <= mul_q30(cy, sp);
			sysp_s1 <= mul_q30(sy, sp);
			cycp_s1 <= mul_q30(cy, cp);
			sycp_s1 <= mul_q30(sy, cp);
			sycr_s1 <= mul_q30(sy, cr);
			sysr_s1 <= mul_q30(sy, sr);
			cycr_s1 <= mul_q30(cy, cr);
			cysr_s1 <= mul_q30(cy, sr);
			cpsr_s1 <= mul_q30(cp, sr);
			cpcr_s1 <= mul_q30(cp, cr);
			sr_s1   <= sr;
			cr_s1   <= cr;
			sp_s1   <= sp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t01_s2  <= mul_q30(cysp_s1, sr_s1);
			t02_s2  <= mul_q30(cysp_s1, cr_s1);
			t11_s2  <= mul_q30(sysp_s1, sr_s1);
			t12_s2  <= mul_q30(sysp_s1, cr_s1);
			cycp_s2 <= cycp_s1;
			sycp_s2 <= sycp_s1;
			sycr_s2 <= sycr_s1;
			sysr_s2 <= sysr_s1;
			cycr_s2 <= cycr_s1;
			cysr_s2 <= cysr_s1;
			cpsr_s2 <= cpsr_s1;
			cpcr_s2 <= cpcr_s1;
			sp_s2   <= sp_s1;
		end
	end

	function automatic logic signed [CW-1:0] ext(input q30_t v);
		return {{(CW-32){v[31]}}, v};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s3.m00 <= to_elem(ext(cycp_s2));
			mat_s3.m01 <= to_elem(ext(t01_s2) - ext(sycr_s2));
			mat_s3.m02 <= to_elem(ext(t02_s2) + ext(sysr_s2));
			mat_s3.m10 <= to_elem(ext(sycp_s2));
			mat_s3.m11 <= to_elem(ext(t11_s2) + ext(cycr_s2));
			mat_s3.m12 <= to_elem(ext(t12_s2) - ext(cysr_s2));
			mat_s3.m20 <= to_elem(-ext(sp_s2));
			mat_s3.m21 <= to_elem(ext(cpsr_s2));
			mat_s3.m22 <= to_elem(ext(cpcr_s2));
		end
	end

endmodule

### rtl/ezr_checker.sv
// Port-level checker for the rotation matrix block, bound to the top level
`include "euler_zyx_to_rotation_matrix_assert.svh"

module ezr_checker import ezr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    angle_valid,
	input logic    angle_stall,
	input angles_t angles,
	input logic    mat_valid,
	input logic    mat_stall,
	input matrix_t matrix
);

	logic range_ok;

	assign range_ok = (matrix.m00 <= (1 << FRAC_BITS)) && (matrix.m00 >= -(1 << FRAC_BITS))
		&& (matrix.m11 <= (1 << FRAC_BITS)) && (matrix.m11 >= -(1 << FRAC_BITS))
		&& (matrix.m22 <= (1 << FRAC_BITS)) && (matrix.m22 >= -(1 << FRAC_BITS));

	`EZR_ASSERT_NEXT(a_hold_valid, mat_valid && mat_stall, mat_valid)
	`EZR_ASSERT_NEXT(a_hold_data, mat_valid && mat_stall, $stable(matrix))
	`EZR_ASSERT_NOW(a_stall_only_on_back, angle_stall, mat_valid && mat_stall)
	`EZR_ASSERT_NOW(a_range, mat_valid, range_ok)
	`EZR_ASSERT_NEXT(a_req_held, angle_valid && angle_stall, angle_valid && $stable(angles))

endmodule

bind euler_zyx_to_rotation_matrix ezr_checker u_ezr_checker (.*);
